// ===== hw/rtl/deq_pkg.sv =====
// Package for the double-ended queue: operation and status codes,
// fixed field widths and the controller/datapath command structs.
// No dependencies.
package deq_pkg;

  localparam int OP_W     = 3;
  localparam int DIN_W    = 32;
  localparam int DOUT_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_PEEK_HEAD = 3'd4,
    OP_PEEK_TAIL = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Datapath condition flags seen by the controller
  typedef struct packed {
    logic full;
    logic empty;
  } deq_flags_t;

  // One-cycle command issued by the controller when a beat is accepted
  typedef struct packed {
    logic    load;        // latch a new result
    logic    wr_en;       // write the pushed word
    logic    wr_at_head;  // write slot is before the head, else at the tail
    logic    rd_en;       // read a word into the result register
    logic    rd_at_tail;  // read slot is before the tail, else at the head
    logic    head_inc;
    logic    head_dec;
    logic    tail_inc;
    logic    tail_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    status_t status;
  } deq_cmd_t;

endpackage

// ===== hw/rtl/deq_if.sv =====
// Valid/ready channel interfaces for the double-ended queue.
// Depends on deq_pkg for field widths.
interface deq_req_if;
  logic                       valid;
  logic                       ready;
  logic [deq_pkg::OP_W-1:0]   operation;
  logic [deq_pkg::DIN_W-1:0]  data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface deq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::DOUT_W-1:0]    data_out;
  logic [deq_pkg::COUNT_W-1:0]   element_count;
  logic [deq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output data_out, output element_count, output status,
                  input ready);
  modport sink   (input valid, input data_out, input element_count, input status,
                  output ready);
endinterface

// ===== hw/rtl/deq_ctrl.sv =====
// Controller for the double-ended queue: handshake state machine and
// operation decode into datapath commands. Depends on deq_pkg.
module deq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic [deq_pkg::OP_W-1:0] operation,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  input  deq_pkg::deq_flags_t      flags,
  output deq_pkg::deq_cmd_t        cmd
);
  import deq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t state;
  logic   rdy;
  logic   vld;
  logic   accept;

  assign req_ready = rdy;
  assign rsp_valid = vld;
  assign accept    = req_valid && rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rdy   <= 1'b1;
      vld   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RESP;
            rdy   <= 1'b0;
            vld   <= 1'b1;
          end
        end
        S_RESP: begin
          if (rsp_ready) begin
            state <= S_IDLE;
            rdy   <= 1'b1;
            vld   <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          rdy   <= 1'b1;
          vld   <= 1'b0;
        end
      endcase
    end
  end

  // Decode the accepted beat; refused operations leave the queue and count unchanged
  always_comb begin
    cmd        = '0;
    cmd.status = ST_OK;
    if (accept) begin
      cmd.load = 1'b1;
      case (op_t'(operation))
        OP_PUSH_HEAD: begin
          if (flags.full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.wr_en      = 1'b1;
            cmd.wr_at_head = 1'b1;
            cmd.head_dec   = 1'b1;
            cmd.cnt_inc    = 1'b1;
          end
        end
        OP_PUSH_TAIL: begin
          if (flags.full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.wr_en    = 1'b1;
            cmd.tail_inc = 1'b1;
            cmd.cnt_inc  = 1'b1;
          end
        end
        OP_POP_HEAD: begin
          if (flags.empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.head_inc = 1'b1;
            cmd.cnt_dec  = 1'b1;
          end
        end
        OP_POP_TAIL: begin
          if (flags.empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.rd_en      = 1'b1;
            cmd.rd_at_tail = 1'b1;
            cmd.tail_dec   = 1'b1;
            cmd.cnt_dec    = 1'b1;
          end
        end
        OP_PEEK_HEAD: begin
          if (flags.empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
        OP_PEEK_TAIL: begin
          if (flags.empty) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.rd_en      = 1'b1;
            cmd.rd_at_tail = 1'b1;
          end
        end
        default: begin
          cmd.status = ST_OK;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/deq_dp.sv =====
// Datapath for the double-ended queue: ring buffer memory, head/tail
// pointers, element count and result registers. Depends on deq_pkg.
module deq_dp #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  deq_pkg::deq_cmd_t             cmd,
  output deq_pkg::deq_flags_t           flags,
  input  logic [deq_pkg::DIN_W-1:0]     data_in,
  output logic [deq_pkg::DOUT_W-1:0]    data_out,
  output logic [deq_pkg::COUNT_W-1:0]   element_count,
  output logic [deq_pkg::STATUS_W-1:0]  status
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         head;
  logic [AW-1:0]         tail;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] rd_q;
  logic                  rd_sel;
  status_t               status_q;

  logic [AW-1:0]             head_prev;
  logic [AW-1:0]             head_succ;
  logic [AW-1:0]             tail_prev;
  logic [AW-1:0]             tail_succ;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic [DATA_WIDTH+DIN_W-1:0]  din_wide;
  logic [DATA_WIDTH-1:0]        word;
  logic [DATA_WIDTH+DOUT_W-1:0] dout_wide;
  logic [CW+COUNT_W-1:0]        cnt_wide;

  assign head_prev = (head == '0)   ? LAST : head - 1'b1;
  assign head_succ = (head == LAST) ? '0   : head + 1'b1;
  assign tail_prev = (tail == '0)   ? LAST : tail - 1'b1;
  assign tail_succ = (tail == LAST) ? '0   : tail + 1'b1;

  assign wr_addr = cmd.wr_at_head ? head_prev : tail;
  assign rd_addr = cmd.rd_at_tail ? tail_prev : head;

  assign flags.full  = (count == FULL);
  assign flags.empty = (count == '0);

  // Fit the 32-bit field to the stored word width
  assign din_wide = {{DATA_WIDTH{1'b0}}, data_in};
  assign word     = din_wide[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= word;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (cmd.load) begin
      rd_sel   <= cmd.rd_en;
      status_q <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.head_dec) begin
        head <= head_prev;
      end else if (cmd.head_inc) begin
        head <= head_succ;
      end
      if (cmd.tail_inc) begin
        tail <= tail_succ;
      end else if (cmd.tail_dec) begin
        tail <= tail_prev;
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
    end
  end

  assign dout_wide     = {{DOUT_W{1'b0}}, (rd_sel ? rd_q : {DATA_WIDTH{1'b0}})};
  assign data_out      = dout_wide[DOUT_W-1:0];
  assign cnt_wide      = {{COUNT_W{1'b0}}, count};
  assign element_count = cnt_wide[COUNT_W-1:0];
  assign status        = status_q;

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Double-ended queue top level: one request beat in, one response beat out.
// The response beat is valid in the cycle after the request is accepted.
// One operation at a time: the request/response state machine in deq_ctrl
// accepts a beat, then holds the response until it is taken before the next.
// Reset (rst, synchronous, active high) empties the queue: head, tail and count
// go to zero; the element memory is not cleared and needs no clearing pass.
module double_ended_queue_top #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  deq_cmd_t   cmd;
  deq_flags_t flags;

  // Controller: handshake and decode of the operation code
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .operation (req.operation),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // Datapath: ring buffer, pointers, count and the held response beat
  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .flags         (flags),
    .data_in       (req.data_in),
    .data_out      (rsp.data_out),
    .element_count (rsp.element_count),
    .status        (rsp.status)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue_top: directed table, then random
// fill/drain/mixed traffic; every response beat checked against the in-bench deque or a typed row.
// Depends on deq_pkg, the deq_req_if/deq_rsp_if interfaces and the RTL top level.
module tb_top;
  import deq_pkg::*;

  // Full depth of the block, so the element count reaches its largest value, 1024.
  localparam int QUEUE_DEPTH = 1024;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES = 6;

  // Operation codes the block must ignore (outside op_t).
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DOUT_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } deq_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DIN_W-1:0] word;
    logic             typed;   // use the result below instead of the deque model
    deq_result_t      result;
  } stim_row_t;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_PUSH} traffic_mix_t;

  localparam int DIRECTED_ROWS = 25;

  // Directed walk: refusals on an empty queue, spare codes, word extremes at both
  // ends, drain back to empty, then a one-element queue seen from both ends.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_POP_HEAD,  32'h0000_0000, 1'b1, '{32'h0000_0000, 11'd0, ST_EMPTY}},
    '{OP_POP_TAIL,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 11'd0, ST_EMPTY}},
    '{OP_PEEK_HEAD, 32'h0000_0000, 1'b1, '{32'h0000_0000, 11'd0, ST_EMPTY}},
    '{OP_PEEK_TAIL, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 11'd0, ST_EMPTY}},
    '{OP_SPARE_LO,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_SPARE_HI,  32'h0000_0000, 1'b1, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_PUSH_HEAD, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 11'd1, ST_OK}},
    '{OP_PUSH_TAIL, 32'h0000_0000, 1'b1, '{32'h0000_0000, 11'd2, ST_OK}},
    '{OP_PEEK_HEAD, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 11'd2, ST_OK}},
    '{OP_PEEK_TAIL, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 11'd2, ST_OK}},
    '{OP_PUSH_HEAD, 32'h8000_0001, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_PUSH_TAIL, 32'h7FFF_FFFE, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_PUSH_TAIL, 32'h5A5A_5A5A, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_HEAD,  32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_TAIL,  32'h0000_0000, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_TAIL,  32'hFFFF_FFFF, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_HEAD,  32'h0000_0000, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_TAIL,  32'h0000_0000, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_HEAD,  32'h0000_0000, 1'b1, '{32'h0000_0000, 11'd0, ST_EMPTY}},
    '{OP_PUSH_TAIL, 32'h1234_5678, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_PUSH_HEAD, 32'hA5A5_A5A5, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_TAIL,  32'h0000_0000, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_PEEK_TAIL, 32'h0000_0000, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_POP_HEAD,  32'h0000_0000, 1'b0, '{32'h0000_0000, 11'd0, ST_OK}},
    '{OP_PEEK_HEAD, 32'h0000_0000, 1'b1, '{32'h0000_0000, 11'd0, ST_EMPTY}}
  };

  logic clk;
  logic rst;

  deq_req_if req ();
  deq_rsp_if rsp ();

  double_ended_queue_top #(
    .DEPTH      (QUEUE_DEPTH),
    .DATA_WIDTH (DIN_W)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Bench copy of the deque: ring storage, head/tail indexes and element count.
  logic [DIN_W-1:0] ring_words [QUEUE_DEPTH];
  int head_slot;
  int tail_slot;
  int level;

  deq_result_t expected_results [$];

  // Run bookkeeping.
  int  mismatches;
  int  beats_sent;
  int  results_checked;
  int  full_refusals;
  int  empty_refusals;
  int  peak_level;
  bit  steady;           // suppress idling on both sides
  bit  hold_off_request; // ask the receiver for one long stall

  // Apply one operation to the bench deque and return the response it owes.
  function automatic deq_result_t apply_operation(logic [OP_W-1:0] op,
                                                  logic [DIN_W-1:0] word);
    deq_result_t res;
    logic        is_push;
    logic        is_read;
    res.data   = '0;
    res.count  = '0;
    res.status = ST_OK;
    is_push = (op == OP_PUSH_HEAD) || (op == OP_PUSH_TAIL);
    is_read = (op >= OP_POP_HEAD) && (op <= OP_PEEK_TAIL);
    if (is_push && level >= QUEUE_DEPTH) begin
      res.status = ST_FULL;
      full_refusals++;
    end else if (is_read && level == 0) begin
      res.status = ST_EMPTY;
      empty_refusals++;
    end else begin
      case (op)
        OP_PUSH_HEAD: begin
          head_slot = (head_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          ring_words[SLOT_W'(head_slot)] = word;
          level++;
        end
        OP_PUSH_TAIL: begin
          ring_words[SLOT_W'(tail_slot)] = word;
          tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
          level++;
        end
        OP_POP_HEAD: begin
          res.data = ring_words[SLOT_W'(head_slot)];
          head_slot = (head_slot + 1) % QUEUE_DEPTH;
          level--;
        end
        OP_POP_TAIL: begin
          tail_slot = (tail_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
          res.data = ring_words[SLOT_W'(tail_slot)];
          level--;
        end
        OP_PEEK_HEAD: res.data = ring_words[SLOT_W'(head_slot)];
        OP_PEEK_TAIL:
          res.data = ring_words[SLOT_W'((tail_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH)];
        default: ;
      endcase
    end
    if (level > peak_level) peak_level = level;
    res.count = level[COUNT_W-1:0];
    return res;
  endfunction

  // Choose an operation for the given traffic mix; outside MIX_PUSH, three percent are spare codes.
  function automatic logic [OP_W-1:0] pick_operation(traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (mix == MIX_PUSH) return (roll < 50) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
    if (roll < 3) return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    case (mix)
      MIX_FILL: begin
        if (roll < 90) return $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
      end
      MIX_DRAIN: begin
        if (roll < 80) return $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
        if (roll < 90) return $urandom_range(0, 1) ? OP_PEEK_HEAD : OP_PEEK_TAIL;
        return $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
      end
      default: begin
        if (roll < 48) return $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        if (roll < 83) return $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
      end
    endcase
    return OP_W'(OP_POP_HEAD + $urandom_range(0, 3));
  endfunction

  // Offer one request beat, hold it until accepted, then log what it should return.
  // Called at a rising edge; leaves the caller at the edge of acceptance.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DIN_W-1:0] word,
                           input logic typed, input deq_result_t typed_result);
    deq_result_t predicted;
    if (!steady && $urandom_range(0, 99) < 35) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.data_in   <= word;
    do @(posedge clk); while (!req.ready);
    predicted = apply_operation(op, word);
    expected_results.push_back(typed ? typed_result : predicted);
    beats_sent++;
  endtask

  // Random beats with a word that now and then sits at an extreme.
  task automatic run_traffic(input traffic_mix_t mix, input int beats);
    logic [DIN_W-1:0] word;
    deq_result_t      unused_result;
    unused_result = '{DOUT_W'(0), COUNT_W'(0), ST_OK};
    repeat (beats) begin
      case ($urandom_range(0, 19))
        0:       word = '0;
        1:       word = '1;
        2:       word = DIN_W'(1) << $urandom_range(0, DIN_W - 1);
        default: word = $urandom;
      endcase
      send_beat(pick_operation(mix), word, 1'b0, unused_result);
    end
  endtask

  // Drop valid and hold until every outstanding response beat has been checked.
  task automatic wait_for_responses;
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random backpressure, none while steady, and one long counted stall
  // when the sender asks for it so the block backs up into the request side.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= steady || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // Response checker: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    deq_result_t oldest;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected response data=%h count=%0d status=%0d", $realtime,
                   rsp.data_out, rsp.element_count, rsp.status);
      end else begin
        oldest = expected_results.pop_front();
        results_checked++;
        if (rsp.data_out !== oldest.data || rsp.element_count !== oldest.count ||
            rsp.status !== oldest.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: response %0d expected data=%h count=%0d status=%0d",
                     $realtime, results_checked, oldest.data, oldest.count, oldest.status);
            $display("    got data=%h count=%0d status=%0d",
                     rsp.data_out, rsp.element_count, rsp.status);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    head_slot        = 0;
    tail_slot        = 0;
    level            = 0;
    mismatches       = 0;
    beats_sent       = 0;
    results_checked  = 0;
    full_refusals    = 0;
    empty_refusals   = 0;
    peak_level       = 0;
    steady           = 1'b0;
    hold_off_request = 1'b0;
    req.valid     <= 1'b0;
    req.operation <= '0;
    req.data_in   <= '0;

    // Hold reset once, then release it.
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                directed_rows[i].result);

    // Pause the sender until the block has answered everything.
    wait_for_responses();
    @(posedge clk);

    // Mixed traffic around a shallow queue, starting under a long receiver stall.
    hold_off_request = 1'b1;
    run_traffic(MIX_BALANCED, 50);

    // Fill to capacity with pushes only and no idling, then hammer the full queue.
    steady = 1'b1;
    while (level < QUEUE_DEPTH) run_traffic(MIX_PUSH, 1);
    steady = 1'b0;
    run_traffic(MIX_FILL, 30);

    // Pull from both ends of the nearly full queue.
    run_traffic(MIX_DRAIN, 30);

    // Let the last beats drain, then run on for DRAIN_CYCLES to catch late misbehaviour.
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request beats (%0d from the directed table), checked %0d responses.",
             beats_sent, DIRECTED_ROWS, results_checked);
    $display("Peak level %0d of %0d; %0d full and %0d empty refusals; %0d mismatches.",
             peak_level, QUEUE_DEPTH, full_refusals, empty_refusals, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("double_ended_queue_top: match");
    else
      $display("double_ended_queue_top: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timed out with %0d responses still outstanding.", expected_results.size());
    $display("double_ended_queue_top: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/deq_pkg.sv
hw/rtl/deq_if.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_dp.sv
hw/rtl/double_ended_queue_top.sv
test/tb_top.sv
